### design/polyline_crossing_finder_assert.svh
// Assertion macros shared by the crossing finder.
`ifndef POLYLINE_CROSSING_FINDER_ASSERT_SVH
`define POLYLINE_CROSSING_FINDER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PCF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// An antecedent that forces a consequent in the next cycle.
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pcf_pkg.sv
`timescale 1ns / 1ps
package pcf_pkg;
	localparam logic [1:0] OP_LOAD_REF  = 2'd0;
	localparam logic [1:0] OP_LOAD_CURR = 2'd1;
	localparam logic [1:0] OP_SEARCH    = 2'd2;

	typedef struct packed {
		logic signed [31:0] ra;
		logic signed [31:0] dec;
	} point_t;

	// Absolute value of a 33-bit difference.
	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction
endpackage

### design/polyline_crossing_finder.sv
`timescale 1ns / 1ps
// Crossing finder for two sky scan tracks.
// Input channel (valid/ready): op 0 loads a reference point, op 1 a current
// point, op 2 runs a search, op 3 is ignored. While the block is idle a load
// is taken every cycle and gives no result; a load into a full track is dropped.
// A search reads both tracks from two point RAMs with a registered read, one
// point of each track per cycle. It checks the end points, walks both tracks
// step by step, then runs the segment checks and cross products and the two
// coordinate divisions (a shift-add multiply, then a restoring divide). A
// track with fewer than three points skips straight to the result.
// The one result (found, crossing point, indices) waits in an output register
// until the receiver takes it; no new item is accepted while a search runs or
// its result is held, so a stalled receiver stalls the input. Every search
// clears both counts.
// Reset clears the counts and the control state and sets segment_limit to one
// arc minute; the point memories are not cleared.
// The segment limit may be written only while the block is idle.
module polyline_crossing_finder #(
	parameter int MAX_POINTS = 4096,
	parameter int FRAC_BITS  = 22
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] ra,
	input  logic signed [31:0] dec,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic signed [31:0] cross_ra,
	output logic signed [31:0] cross_dec,
	output logic [11:0]        ref_index,
	output logic [11:0]        curr_index,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [30:0] LIMIT_RESET =
		31'(((64'd167 << FRAC_BITS) + 64'd5000) / 64'd10000);

	localparam logic [4:0] S_IDLE = 5'd0,  S_END0 = 5'd1,  S_END1 = 5'd2,
		S_ENDW = 5'd3, S_WREQ = 5'd4, S_WA = 5'd5, S_WB = 5'd6, S_WC = 5'd7,
		S_WEVAL = 5'd8, S_GA = 5'd9, S_GB = 5'd10, S_GC = 5'd11, S_GD = 5'd12,
		S_M1 = 5'd13, S_M2 = 5'd14, S_M3 = 5'd15, S_DIVX = 5'd16,
		S_DIVY = 5'd17, S_FIN = 5'd18, S_OUT = 5'd19, S_M4 = 5'd20;

	logic [4:0]  state_q;
	logic [30:0] limit_q;
	logic [CW-1:0] nr_q, nc_q;

	// Memory ports
	logic r_we, c_we;
	logic [AW-1:0] r_addr, c_addr, r_waddr, c_waddr;
	pcf_pkg::point_t r_rd, c_rd, wpt;

	assign wpt = '{ra: ra, dec: dec};

	pcf_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ref (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(wpt),
		.raddr(r_addr), .rdata(r_rd));
	pcf_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_curr (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(wpt),
		.raddr(c_addr), .rdata(c_rd));

	logic accept;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign r_we     = accept && op == pcf_pkg::OP_LOAD_REF && nr_q < CW'(MAX_POINTS);
	assign c_we     = accept && op == pcf_pkg::OP_LOAD_CURR && nc_q < CW'(MAX_POINTS);
	assign r_waddr  = nr_q[AW-1:0];
	assign c_waddr  = nc_q[AW-1:0];

	// Search registers
	logic [CW-1:0] i_q, j_q;
	logic signed [31:0] r0ra_q, rlra_q, c0ra_q;
	logic signed [31:0] rmax_q, rmin_q;
	pcf_pkg::point_t ri_q, ri1_q, cj_q, cj1_q, rm_q, cm_q;
	logic [AW-1:0] ra_q, ca_q;

	always_comb begin
		r_addr = ra_q;
		c_addr = ca_q;
	end

	// Walk comparisons
	logic signed [32:0] d1, d2, d3, d4, d5, d6, d7, d8;
	always_comb begin
		d1 = 33'(ri1_q.ra) - 33'(cj_q.ra);
		d2 = 33'(ri_q.ra) - 33'(cj_q.ra);
		d3 = 33'(cj1_q.ra) - 33'(ri_q.ra);
		d4 = 33'(cj_q.ra) - 33'(ri_q.ra);
		d5 = 33'(ri1_q.dec) - 33'(cj_q.dec);
		d6 = 33'(ri_q.dec) - 33'(cj_q.dec);
		d7 = 33'(cj1_q.dec) - 33'(ri_q.dec);
		d8 = 33'(cj_q.dec) - 33'(ri_q.dec);
	end
	logic step_i, step_j;
	always_comb begin
		step_i = 1'b0;
		step_j = 1'b0;
		if (pcf_pkg::mag33(d1) < pcf_pkg::mag33(d2))
			step_i = 1'b1;
		else if (pcf_pkg::mag33(d3) < pcf_pkg::mag33(d4))
			step_j = 1'b1;
		else if (pcf_pkg::mag33(d5) < pcf_pkg::mag33(d6))
			step_i = 1'b1;
		else if (pcf_pkg::mag33(d7) < pcf_pkg::mag33(d8))
			step_j = 1'b1;
	end

	// Geometry: x1 y1 (R[i-1]) x2 y2 (R[i+1]) x3 y3 (C[j-1]) x4 y4 (C[j+1])
	logic signed [32:0] dx12_q, dy12_q, dx34_q, dy34_q, ex_q, ey_q;
	logic signed [65:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
	logic signed [66:0] dd_q, na_q, nb_q;
	logic [65:0] sq_q [4];
	logic ok_q;
	logic [63:0] md, ma;
	assign md = dd_q[66] ? 64'(-dd_q) : 64'(dd_q);
	assign ma = na_q[66] ? 64'(-na_q) : 64'(na_q);

	logic [32:0] adx12, ady12, adx34, ady34, aex, aey;
	assign adx12 = pcf_pkg::mag33(dx12_q);
	assign ady12 = pcf_pkg::mag33(dy12_q);
	assign adx34 = pcf_pkg::mag33(dx34_q);
	assign ady34 = pcf_pkg::mag33(dy34_q);
	assign aex   = pcf_pkg::mag33(ex_q);
	assign aey   = pcf_pkg::mag33(ey_q);

	// Divider
	logic div_start, div_done;
	logic [63:0]  div_q;
	logic [32:0]  dmul_q;
	pcf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(ma), .b(dmul_q),
		.den(md), .done(div_done), .quo(div_q));

	logic signed [31:0] cra_q, cdec_q;
	logic signed [33:0] cra_w, cdec_w;
	assign cra_w  = dx12_q[32] ? 34'(rm_q.ra) - 34'(div_q) : 34'(rm_q.ra) + 34'(div_q);
	assign cdec_w = dy12_q[32] ? 34'(rm_q.dec) - 34'(div_q) : 34'(rm_q.dec) + 34'(div_q);

	// Refine: registers for R[i-1], R[i+1], C[j-1], C[j+1] ra loaded in GB and GC.
	logic signed [31:0] rprev_q, rnext_q, cprev_q, cnext_q;
	function automatic logic [CW-1:0] pick(input logic [CW-1:0] k,
			input logic signed [31:0] x, input logic signed [31:0] pv,
			input logic signed [31:0] hr, input logic signed [31:0] nx);
		logic [32:0] h;
		h = pcf_pkg::mag33(33'(x) - 33'(hr));
		if (pcf_pkg::mag33(33'(x) - 33'(nx)) < h)
			pick = k + CW'(1);
		else if (pcf_pkg::mag33(33'(x) - 33'(pv)) < h)
			pick = k - CW'(1);
		else
			pick = k;
	endfunction

	logic [65:0] lim2;
	assign lim2 = 66'(limit_q) * 66'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			limit_q   <= LIMIT_RESET;
			nr_q      <= '0;
			nc_q      <= '0;
			out_valid <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (r_we)
				nr_q <= nr_q + CW'(1);
			if (c_we)
				nc_q <= nc_q + CW'(1);
			case (state_q)
			S_IDLE: begin
				if (accept && op == pcf_pkg::OP_SEARCH) begin
					ok_q <= 1'b0;
					if (nr_q < CW'(3) || nc_q < CW'(3)) begin
						state_q <= S_FIN;
					end else begin
						ra_q    <= '0;
						ca_q    <= '0;
						state_q <= S_END0;
					end
				end
			end
			S_END0: begin
				ra_q    <= AW'(nr_q - CW'(1));
				ca_q    <= AW'(nc_q - CW'(1));
				state_q <= S_END1;
			end
			S_END1: begin
				r0ra_q  <= r_rd.ra;
				c0ra_q  <= c_rd.ra;
				state_q <= S_ENDW;
			end
			S_ENDW: begin
				if (r0ra_q >= r_rd.ra) begin
					rmax_q <= r0ra_q; rmin_q <= r_rd.ra;
				end else begin
					rmax_q <= r_rd.ra; rmin_q <= r0ra_q;
				end
				rlra_q <= (c0ra_q >= c_rd.ra) ? c_rd.ra : c0ra_q;
				c0ra_q <= (c0ra_q >= c_rd.ra) ? c0ra_q : c_rd.ra;
				i_q <= CW'(1);
				j_q <= CW'(1);
				state_q <= S_M4;
			end
			S_M4: begin
				// rlra_q holds cmin, c0ra_q cmax.
				if (rlra_q > rmax_q || c0ra_q < rmin_q)
					state_q <= S_FIN;
				else
					state_q <= S_WREQ;
			end
			S_WREQ: begin
				ra_q    <= i_q[AW-1:0];
				ca_q    <= j_q[AW-1:0];
				state_q <= S_WA;
			end
			S_WA: begin
				ra_q    <= AW'(i_q + CW'(1));
				ca_q    <= AW'(j_q + CW'(1));
				state_q <= S_WB;
			end
			S_WB: begin
				ri_q    <= r_rd;
				cj_q    <= c_rd;
				state_q <= S_WC;
			end
			S_WC: begin
				ri1_q   <= r_rd;
				cj1_q   <= c_rd;
				state_q <= S_WEVAL;
			end
			S_WEVAL: begin
				if (step_i || step_j) begin
					if ((step_i ? i_q + CW'(2) : i_q + CW'(1)) >= nr_q ||
							(step_j ? j_q + CW'(2) : j_q + CW'(1)) >= nc_q) begin
						state_q <= S_FIN;
					end else begin
						if (step_i) i_q <= i_q + CW'(1);
						if (step_j) j_q <= j_q + CW'(1);
						state_q <= S_WREQ;
					end
				end else begin
					ra_q    <= AW'(i_q - CW'(1));
					ca_q    <= AW'(j_q - CW'(1));
					state_q <= S_GA;
				end
			end
			S_GA: begin
				ra_q    <= AW'(i_q + CW'(1));
				ca_q    <= AW'(j_q + CW'(1));
				state_q <= S_GB;
			end
			S_GB: begin
				rm_q    <= r_rd;
				cm_q    <= c_rd;
				rprev_q <= r_rd.ra;
				cprev_q <= c_rd.ra;
				state_q <= S_GC;
			end
			S_GC: begin
				rnext_q <= r_rd.ra;
				cnext_q <= c_rd.ra;
				dx12_q  <= 33'(r_rd.ra) - 33'(rm_q.ra);
				dy12_q  <= 33'(r_rd.dec) - 33'(rm_q.dec);
				dx34_q  <= 33'(c_rd.ra) - 33'(cm_q.ra);
				dy34_q  <= 33'(c_rd.dec) - 33'(cm_q.dec);
				ex_q    <= 33'(rm_q.ra) - 33'(cm_q.ra);
				ey_q    <= 33'(rm_q.dec) - 33'(cm_q.dec);
				state_q <= S_GD;
			end
			S_GD: begin
				// Length limits on squares and the far-segment check.
				sq_q[0] <= 66'(adx12) * 66'(adx12);
				sq_q[1] <= 66'(ady12) * 66'(ady12);
				sq_q[2] <= 66'(adx34) * 66'(adx34);
				sq_q[3] <= 66'(ady34) * 66'(ady34);
				ok_q <= adx12 <= 33'(limit_q) && ady12 <= 33'(limit_q) &&
					adx34 <= 33'(limit_q) && ady34 <= 33'(limit_q) &&
					aex <= {1'b0, limit_q, 1'b0} && aey <= {1'b0, limit_q, 1'b0};
				state_q <= S_M1;
			end
			S_M1: begin
				if (!ok_q || 67'(sq_q[0]) + 67'(sq_q[1]) > 67'(lim2) ||
						67'(sq_q[2]) + 67'(sq_q[3]) > 67'(lim2)) begin
					ok_q    <= 1'b0;
					state_q <= S_FIN;
				end else begin
					p1_q <= dy34_q * dx12_q;
					p2_q <= dx34_q * dy12_q;
					p3_q <= dx34_q * ey_q;
					p4_q <= dy34_q * ex_q;
					p5_q <= dx12_q * ey_q;
					p6_q <= dy12_q * ex_q;
					state_q <= S_M2;
				end
			end
			S_M2: begin
				dd_q <= 67'(p1_q) - 67'(p2_q);
				na_q <= 67'(p3_q) - 67'(p4_q);
				nb_q <= 67'(p5_q) - 67'(p6_q);
				state_q <= S_M3;
			end
			S_M3: begin
				if (dd_q == '0 ||
						!(na_q == '0 || (na_q[66] == dd_q[66] && ma <= md)) ||
						!(nb_q == '0 || (nb_q[66] == dd_q[66] &&
						(nb_q[66] ? 64'(-nb_q) : 64'(nb_q)) <= md))) begin
					ok_q    <= 1'b0;
					state_q <= S_FIN;
				end else begin
					dmul_q    <= adx12;
					div_start <= 1'b1;
					state_q   <= S_DIVX;
				end
			end
			S_DIVX: begin
				if (div_done) begin
					cra_q     <= 32'(cra_w);
					dmul_q    <= ady12;
					div_start <= 1'b1;
					state_q   <= S_DIVY;
				end
			end
			S_DIVY: begin
				if (div_done) begin
					cdec_q <= 32'(cdec_w);
					ok_q   <= !(cra_q > rmax_q || cra_q < rmin_q);
					state_q <= S_FIN;
				end
			end
			S_FIN: begin
				found      <= ok_q;
				cross_ra   <= ok_q ? cra_q : '0;
				cross_dec  <= ok_q ? cdec_q : '0;
				ref_index  <= ok_q ? 12'(pick(i_q, cra_q, rprev_q, ri_q.ra, rnext_q)) : '0;
				curr_index <= ok_q ? 12'(pick(j_q, cra_q, cprev_q, cj_q.ra, cnext_q)) : '0;
				nr_q       <= '0;
				nc_q       <= '0;
				out_valid  <= 1'b1;
				state_q    <= S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "polyline_crossing_finder_assert.svh"

	`PCF_ASSERT_ALWAYS(a_out_only_in_out, !out_valid || state_q == S_OUT,
		"result shown outside output state")
	`PCF_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(cross_ra),
		"held result changed")
	`PCF_ASSERT_ALWAYS(a_count_bound, nr_q <= CW'(MAX_POINTS) && nc_q <= CW'(MAX_POINTS),
		"track count past capacity")
endmodule

### design/pcf_ram.sv
`timescale 1ns / 1ps
module pcf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### design/pcf_divider.sv
`timescale 1ns / 1ps
module pcf_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [32:0] b,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	// round(a * b / den), ties away from zero. A shift-add multiply builds the
	// 97-bit product, then a restoring divide takes one quotient bit per cycle.
	logic [96:0] n_q;
	logic [63:0] a_q;
	logic [32:0] b_q;
	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [6:0]  cnt_q;
	logic        mul_q;
	logic        busy_q;
	logic [64:0] rs;
	logic [64:0] diff;

	assign rs   = {rem_q, n_q[96]};
	assign diff = rs - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
				cnt_q  <= 7'd33;
			end else if (busy_q) begin
				if (cnt_q == 7'd1) begin
					if (mul_q) begin
						mul_q <= 1'b0;
						cnt_q <= 7'd97;
					end else begin
						busy_q <= 1'b0;
						done   <= 1'b1;
						cnt_q  <= '0;
					end
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			n_q   <= '0;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q && mul_q) begin
			// Multiplier bits are taken most significant first.
			n_q <= {n_q[95:0], 1'b0} + (b_q[32] ? {33'd0, a_q} : 97'd0);
			b_q <= {b_q[31:0], 1'b0};
		end else if (busy_q) begin
			n_q <= {n_q[95:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= rs[63:0];
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	// Round: rem >= den - rem.
	assign quo = (rem_q >= den - rem_q) ? q_q + 64'd1 : q_q;
endmodule
